@@ rtl/lsr_pkg.sv @@
// Shared types, constants and controller/datapath handshake structs for the LIS unit.
package lsr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 7;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [LenW-1:0]          len_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_UPD_RD,
    S_UPD_WR,
    S_WALK_CHK,
    S_WALK_LOAD,
    S_WALK_PUSH,
    S_WALK_NEXT,
    S_EMIT_STK,
    S_EMIT_VAL,
    S_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic drop;
    logic search;
    logic tp_rd_prev;
    logic update;
    logic walk_init;
    logic walk_load;
    logic walk_push;
    logic walk_next;
    logic emit_stack;
    logic emit_val;
    logic emit_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic search_more;
    logic tail_empty;
    logic walk_done;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

@@ rtl/lsr_ifs.sv @@
// Valid/ready channel interfaces for sequence input beats and subsequence output beats.
interface lsr_in_if;
  import lsr_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lsr_out_if;
  import lsr_pkg::*;

  logic   valid;
  logic   ready;
  value_t element;
  len_t   lis_length;
  logic   end_of_run;
  logic   overflow;

  modport source (output valid, output element, output lis_length, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input element, input lis_length, input end_of_run,
                  input overflow, output ready);
endinterface

@@ rtl/lsr_ctrl.sv @@
// Sequencer for search, table update, predecessor walk and result emission.
module lsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lsr_pkg::stat_t stat_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output lsr_pkg::cmd_t cmd_o
);
  import lsr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (!stat_i.full) state_d = S_SEARCH;
        else if (stat_i.last) state_d = S_WALK_CHK;
        else state_d = S_IDLE;
      end
      S_SEARCH:    if (!stat_i.search_more) state_d = S_UPD_RD;
      S_UPD_RD:    state_d = S_UPD_WR;
      S_UPD_WR:    state_d = stat_i.last ? S_WALK_CHK : S_IDLE;
      S_WALK_CHK:  state_d = stat_i.tail_empty ? S_IDLE : S_WALK_LOAD;
      S_WALK_LOAD: state_d = S_WALK_PUSH;
      S_WALK_PUSH: state_d = S_WALK_NEXT;
      S_WALK_NEXT: state_d = stat_i.walk_done ? S_EMIT_STK : S_WALK_PUSH;
      S_EMIT_STK:  state_d = S_EMIT_VAL;
      S_EMIT_VAL:  state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (stat_i.out_free) state_d = stat_i.emit_last ? S_IDLE : S_EMIT_STK;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.drop  = stat_i.full;
        cmd_o.clear = stat_i.full && !stat_i.last ? 1'b0 : 1'b0;
      end
      S_SEARCH:    cmd_o.search     = 1'b1;
      S_UPD_RD:    cmd_o.tp_rd_prev = 1'b1;
      S_UPD_WR:    cmd_o.update     = 1'b1;
      S_WALK_CHK: begin
        cmd_o.walk_init = !stat_i.tail_empty;
        cmd_o.clear     = stat_i.tail_empty;
      end
      S_WALK_LOAD: cmd_o.walk_load  = 1'b1;
      S_WALK_PUSH: cmd_o.walk_push  = 1'b1;
      S_WALK_NEXT: cmd_o.walk_next  = 1'b1;
      S_EMIT_STK:  cmd_o.emit_stack = 1'b1;
      S_EMIT_VAL:  cmd_o.emit_val   = 1'b1;
      S_EMIT_OUT: begin
        cmd_o.emit_load = stat_i.out_free;
        cmd_o.clear     = stat_i.out_free && stat_i.emit_last;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/lsr_datapath.sv @@
// Tail table, item and chain memories, binary search step and output register.
module lsr_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsr_pkg::cmd_t    cmd_i,
  output lsr_pkg::stat_t   stat_o,
  input  lsr_pkg::value_t  in_value_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output lsr_pkg::value_t  out_element_o,
  output lsr_pkg::len_t    out_lis_length_o,
  output logic             out_end_of_run_o,
  output logic             out_overflow_o
);
  import lsr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  value_t        tail_val_mem [MAX_ITEMS];
  logic [IW-1:0] tail_pos_mem [MAX_ITEMS];
  logic [IW:0]   pred_mem     [MAX_ITEMS];
  value_t        stored_mem   [MAX_ITEMS];
  logic [IW-1:0] stack_mem    [MAX_ITEMS];

  value_t        tv_rd_q, sv_rd_q;
  logic [IW-1:0] tp_rd_q, stk_rd_q;
  logic [IW:0]   pred_rd_q;

  value_t        value_q;
  logic          last_q;
  logic [CW-1:0] item_cnt_q, tail_len_q;
  logic          dropped_q;
  logic [CW-1:0] lo_q, hi_q, mid_q;
  logic          pend_q;
  logic [IW-1:0] pos_q, cur_q;
  logic [CW-1:0] depth_q, k_q;

  logic          out_valid_q;
  value_t        out_element_q;
  len_t          out_len_q;
  logic          out_end_q, out_ovf_q;

  logic          lt;
  logic [CW-1:0] lo_n, hi_n, mid_n;
  logic [CW:0]   mid_sum;
  logic          search_more;
  logic          emit_last;
  logic [CW-1:0] stk_addr, tp_addr;
  logic [IW-1:0] item_idx;

  assign lt          = tv_rd_q < value_q;
  assign lo_n        = (pend_q && lt) ? mid_q + CW'(1) : lo_q;
  assign hi_n        = (pend_q && !lt) ? mid_q : hi_q;
  assign mid_sum     = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n       = mid_sum[CW:1];
  assign search_more = lo_n < hi_n;
  assign emit_last   = (k_q + CW'(1)) == depth_q;
  assign stk_addr    = depth_q - k_q - CW'(1);
  assign tp_addr     = cmd_i.walk_init ? tail_len_q - CW'(1) : CW'(pos_q) - CW'(1);
  assign item_idx    = item_cnt_q[IW-1:0];

  always_comb begin
    stat_o             = '0;
    stat_o.full        = item_cnt_q == CW'(MAX_ITEMS);
    stat_o.last        = last_q;
    stat_o.search_more = search_more;
    stat_o.tail_empty  = tail_len_q == '0;
    stat_o.walk_done   = pred_rd_q[IW] || (depth_q == tail_len_q);
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.emit_last   = emit_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search && search_more) begin
      tv_rd_q <= tail_val_mem[mid_n[IW-1:0]];
    end
    if (cmd_i.tp_rd_prev || cmd_i.walk_init) begin
      tp_rd_q <= tail_pos_mem[tp_addr[IW-1:0]];
    end
    if (cmd_i.walk_push) begin
      pred_rd_q <= pred_mem[cur_q];
      stack_mem[depth_q[IW-1:0]] <= cur_q;
    end
    if (cmd_i.emit_stack) begin
      stk_rd_q <= stack_mem[stk_addr[IW-1:0]];
    end
    if (cmd_i.emit_val) begin
      sv_rd_q <= stored_mem[stk_rd_q];
    end
    if (cmd_i.update) begin
      stored_mem[item_idx]  <= value_q;
      tail_val_mem[pos_q]   <= value_q;
      tail_pos_mem[pos_q]   <= item_idx;
      pred_mem[item_idx]    <= (pos_q == '0) ? {1'b1, IW'(0)} : {1'b0, tp_rd_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= in_value_i;
      last_q  <= in_last_i;
      lo_q    <= '0;
      hi_q    <= tail_len_q;
      mid_q   <= '0;
    end
    if (cmd_i.search) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
      pos_q <= lo_n[IW-1:0];
    end
    if (cmd_i.walk_init) begin
      k_q <= '0;
    end
    if (cmd_i.walk_load) begin
      cur_q <= tp_rd_q;
    end
    if (cmd_i.walk_next && !stat_o.walk_done) begin
      cur_q <= pred_rd_q[IW-1:0];
    end
    if (cmd_i.emit_load) begin
      out_element_q <= sv_rd_q;
      out_len_q     <= LenW'(depth_q);
      out_end_q     <= emit_last;
      out_ovf_q     <= dropped_q;
      k_q           <= k_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cnt_q  <= '0;
      tail_len_q  <= '0;
      dropped_q   <= 1'b0;
      pend_q      <= 1'b0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.search) begin
        pend_q <= search_more;
      end
      if (cmd_i.drop) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.update) begin
        item_cnt_q <= item_cnt_q + CW'(1);
        if (CW'(pos_q) >= tail_len_q) begin
          tail_len_q <= CW'(pos_q) + CW'(1);
        end
      end
      if (cmd_i.walk_init) begin
        depth_q <= '0;
      end
      if (cmd_i.walk_push) begin
        depth_q <= depth_q + CW'(1);
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        item_cnt_q <= '0;
        tail_len_q <= '0;
        dropped_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_element_o    = out_element_q;
  assign out_lis_length_o = out_len_q;
  assign out_end_of_run_o = out_end_q;
  assign out_overflow_o   = out_ovf_q;

  a_tail_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_len_q <= item_cnt_q) else $error("tail table longer than item count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_cnt_q <= CW'(MAX_ITEMS)) else $error("item count beyond capacity");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before its beat was taken");

  a_update_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (item_cnt_q < CW'(MAX_ITEMS)))
    else $error("table update while storage is full");

  a_walk_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_push |-> (depth_q < tail_len_q))
    else $error("predecessor walk deeper than tail table");

endmodule

@@ rtl/lis_sequence_reconstruct_unit.sv @@
// Non-last beat: check, then a binary search of P probes (P <= 6 at 64 items), then table update.
// Binary search issues one tail-table read per cycle; the update reads, then writes the tables.
// Last beat adds a predecessor walk of L steps (memory read per step), L = LIS length, and
// per emitted element a stack read, value read and output load (waits for a free output).
// One sequence item is processed at a time; the output register lets the next input start.
// Reset (rst_ni low, async) clears counters, drop flag, FSM and output valid; no sweep.
module lis_sequence_reconstruct_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsr_in_if.sink    in_i,
  lsr_out_if.source out_o
);
  import lsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready = in_ready;

  lsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  lsr_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_value_i       (in_i.value),
    .in_last_i        (in_i.last),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_element_o    (out_o.element),
    .out_lis_length_o (out_o.lis_length),
    .out_end_of_run_o (out_o.end_of_run),
    .out_overflow_o   (out_o.overflow)
  );

endmodule

@@ dv/tb_top.sv @@
// Testbench for lis_sequence_reconstruct_unit: directed table, then random sequences.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsr_pkg::*;

  localparam int unsigned LIS_CAP    = 64;
  localparam int unsigned RAND_ITEMS = 140;
  localparam int unsigned CALM_ITEMS = 30;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned DIR_ROWS_N = 21;
  localparam value_t      VAL_MAX    = 32'sh7FFF_FFFF;
  localparam value_t      VAL_MIN    = 32'sh8000_0000;
  localparam int          NO_PRED    = -1;

  typedef struct {
    value_t element;
    len_t   lis_length;
    logic   end_of_run;
    logic   overflow;
  } lis_beat_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   typed;
    value_t typed_elem;
  } dir_row_t;

  typedef enum int {
    MIX_WIDE,
    MIX_NARROW,
    MIX_RISING,
    MIX_EXTREME
  } mix_e;

  // typed rows expect a single-element run holding typed_elem
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
    '{32'sd0,  1'b1, 1'b1, 32'sd0},
    '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
    '{32'sd0,  1'b0, 1'b0, 32'sd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0},
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
    '{32'sd5,  1'b0, 1'b0, 32'sd0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0},
    '{32'sd5,  1'b1, 1'b1, 32'sd5},
    '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0},
    '{32'sd0,  1'b0, 1'b0, 32'sd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0},
    '{VAL_MAX, 1'b1, 1'b0, 32'sd0},
    '{32'sd3,  1'b0, 1'b0, 32'sd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0},
    '{32'sd2,  1'b0, 1'b0, 32'sd0},
    '{32'sd2,  1'b0, 1'b0, 32'sd0},
    '{32'sd4,  1'b0, 1'b0, 32'sd0},
    '{32'sd3,  1'b1, 1'b0, 32'sd0}
  };

  logic clk_i;
  logic rst_ni;

  lsr_in_if  in_bus ();
  lsr_out_if out_bus ();

  lis_sequence_reconstruct_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predictor state
  value_t      tail_val [LIS_CAP];
  int unsigned tail_pos [LIS_CAP];
  int          pred_idx [LIS_CAP];
  value_t      seq_vals [LIS_CAP];
  int unsigned seq_count;
  int unsigned tail_len;
  bit          seq_dropped;

  lis_beat_t   pending_beats [$];
  int unsigned bad_beats;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned runs_seen;
  int unsigned longest_run;
  int unsigned overflow_runs;

  bit          calm;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void lis_absorb(value_t v, logic is_last, bit publish);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned depth;
    int unsigned cur;
    int unsigned chain [LIS_CAP];
    lis_beat_t   beat;
    if (seq_count < LIS_CAP) begin
      lo = 0;
      hi = tail_len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tail_val[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      seq_vals[seq_count] = v;
      if (lo >= tail_len) tail_len = lo + 1;
      tail_val[lo] = v;
      tail_pos[lo] = seq_count;
      pred_idx[seq_count] = (lo > 0) ? int'(tail_pos[lo-1]) : NO_PRED;
      seq_count++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (!is_last) return;
    if (tail_len != 0) begin
      depth = 0;
      cur = tail_pos[tail_len-1];
      while (depth < tail_len) begin
        chain[depth] = cur;
        depth++;
        if (pred_idx[cur] == NO_PRED) break;
        cur = pred_idx[cur];
      end
      runs_seen++;
      if (depth > longest_run) longest_run = depth;
      if (seq_dropped) overflow_runs++;
      if (publish) begin
        for (int unsigned k = 0; k < depth; k++) begin
          beat.element    = seq_vals[chain[depth-1-k]];
          beat.lis_length = len_t'(depth);
          beat.end_of_run = (k + 1 == depth);
          beat.overflow   = seq_dropped;
          pending_beats   = {pending_beats, beat};
        end
      end
    end
    seq_count   = 0;
    tail_len    = 0;
    seq_dropped = 1'b0;
  endfunction

  function automatic value_t pick_value(mix_e mix, int unsigned idx);
    case (mix)
      MIX_NARROW:  return value_t'($urandom_range(0, 15)) - 32'sd8;
      MIX_RISING:  return value_t'(idx * 100 + $urandom_range(0, 150)) - 32'sd2000;
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return -32'sd1;
          3:       return 32'sd0;
          default: return value_t'($urandom);
        endcase
      end
      default:     return value_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(input value_t v, input logic is_last, input bit publish);
    if (!calm && ($urandom_range(0, 99) < src_idle_pct)) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    in_bus.last  <= is_last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    beats_in++;
    lis_absorb(v, is_last, publish);
  endtask

  task automatic check_beat();
    lis_beat_t want;
    beats_out++;
    if (pending_beats.size() == 0) begin
      $error("unexpected result beat: element %0d", out_bus.element);
      bad_beats++;
      return;
    end
    want = pending_beats.pop_front();
    if (out_bus.element !== want.element) begin
      $error("element: expected %0d, got %0d", want.element, out_bus.element);
      bad_beats++;
    end
    if (out_bus.lis_length !== want.lis_length) begin
      $error("lis_length: expected %0d, got %0d", want.lis_length, out_bus.lis_length);
      bad_beats++;
    end
    if (out_bus.end_of_run !== want.end_of_run) begin
      $error("end_of_run: expected %0b, got %0b", want.end_of_run, out_bus.end_of_run);
      bad_beats++;
    end
    if (out_bus.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, out_bus.overflow);
      bad_beats++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        check_beat();
        // hold off once during a long run so the block backs up its input
        if (!long_hold_done && out_bus.lis_length >= 20) begin
          long_hold_done = 1'b1;
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && ($urandom_range(0, 99) < sink_idle_pct)) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned seq_len;
    bit          long_done;
    mix_e        mix;
    value_t      v;
    lis_beat_t   typed_beat;
    seq_count     = 0;
    tail_len      = 0;
    seq_dropped   = 1'b0;
    bad_beats     = 0;
    beats_in      = 0;
    beats_out     = 0;
    runs_seen     = 0;
    longest_run   = 0;
    overflow_runs = 0;
    calm          = 1'b0;
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    in_bus.last  <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      send_beat(DIR_ROWS[r].value, DIR_ROWS[r].last, !DIR_ROWS[r].typed);
      if (DIR_ROWS[r].typed) begin
        typed_beat = '{DIR_ROWS[r].typed_elem, len_t'(1), 1'b1, 1'b0};
        pending_beats = {pending_beats, typed_beat};
      end
    end

    total     = 0;
    long_done = 1'b0;
    while (total < RAND_ITEMS) begin
      calm = (total + CALM_ITEMS >= RAND_ITEMS);
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 25;
        default: src_idle_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_idle_pct = 0;
        1:       sink_idle_pct = 20;
        default: sink_idle_pct = 50;
      endcase
      if (!long_done && total >= 40) begin
        // full table of rising values, then dropped beats, last one dropped too
        long_done = 1'b1;
        seq_len = LIS_CAP + 3;
        for (int unsigned i = 0; i < seq_len; i++) begin
          if (i < LIS_CAP)
            v = value_t'(32'h8000_0000 + (i << 25) + $urandom_range(0, (1 << 25) - 1));
          else
            v = value_t'($urandom);
          send_beat(v, i == seq_len - 1, 1'b1);
        end
      end else begin
        seq_len = $urandom_range(1, 12);
        mix = mix_e'($urandom_range(0, 3));
        for (int unsigned i = 0; i < seq_len; i++)
          send_beat(pick_value(mix, i), i == seq_len - 1, 1'b1);
      end
      total += seq_len;
    end
    in_bus.valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d input beats in %0d sequences; checked %0d result beats.",
             beats_in, runs_seen, beats_out);
    $display("Longest subsequence %0d, runs with dropped beats %0d.",
             longest_run, overflow_runs);
    if (bad_beats == 0 && pending_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ lis_sequence_reconstruct_unit.f @@
rtl/lsr_pkg.sv
rtl/lsr_ifs.sv
rtl/lsr_ctrl.sv
rtl/lsr_datapath.sv
rtl/lis_sequence_reconstruct_unit.sv
dv/tb_top.sv
